// File: sv/gdw_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the graph walker
// no dependencies
package gdw_pkg;

    localparam int NODE_W = 6;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_DFS = 2'd1,
        CMD_BFS = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_VISIT = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_E_DEGA,
        S_E_DEGB,
        S_E_SCAN,
        S_E_CMP,
        S_E_WRA,
        S_E_WRB,
        S_E_EMIT,
        S_D_LOAD,
        S_D_LOADW,
        S_D_STEP,
        S_D_NEXT,
        S_D_POPW,
        S_B_POP,
        S_B_POPW,
        S_B_EMIT,
        S_B_DEGW,
        S_B_SCAN,
        S_B_CHK,
        S_FIN
    } t_state;

endpackage

// File: sv/gdw_ram.sv
`timescale 1ns / 1ps
// simple dual-port ram, one write and one registered read port
// no dependencies
module gdw_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/graph_dfs_bfs_walker.sv
`timescale 1ns / 1ps
// graph walker top: adjacency lists, degree table, dfs stack and bfs queue in rams
// depends on gdw_pkg and gdw_ram
//
// channel   dir  tdata                           tuser      tlast
// s         in   [5:0] node_a, [11:6] node_b    [1:0] cmd  -
// m         out  [5:0] visited_node, [7:6] stat -          last
//
// add edge: reads both degrees, scans node_a's list for a duplicate, then appends; one result
// walks: every adjacency entry is read through the single read port of the neighbour ram;
// one result per reached node
// reset clears control, degree valid bits and visited map; no clearing pass
// a stalled output holds the walk in place; input is taken only when idle
module graph_dfs_bfs_walker #(
    parameter int MAX_NODES  = 32,
    parameter int MAX_DEGREE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] node_a, [11:6] node_b, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] visited_node, [7:6] status
    output logic        m_tlast
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int DCW = $clog2(MAX_DEGREE + 1);
    localparam int DIW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int AW  = $clog2(MAX_NODES * MAX_DEGREE);
    localparam int QW  = $clog2(MAX_NODES + 1);
    localparam int NDW = gdw_pkg::NODE_W;
    localparam int SW  = NDW + DCW;

    gdw_pkg::t_state r_state, n_state;

    logic [NDW-1:0] r_a, n_a, r_b, n_b, r_here, n_here, r_pend, n_pend;
    logic [DCW-1:0] r_dega, n_dega, r_degb, n_degb, r_j, n_j;
    logic [NW-1:0]  r_sp, n_sp;
    logic [QW-1:0]  r_head, n_head, r_tail, n_tail;
    logic [MAX_NODES-1:0] r_visited, n_visited, r_deg_vld;
    logic           r_pend_vld, n_pend_vld, r_rd_vld;
    gdw_pkg::t_status r_status, n_status;

    logic           r_ovalid;
    logic [NDW-1:0] r_onode;
    logic [1:0]     r_ostat;
    logic           r_olast;
    logic           out_free, out_push, out_last;
    logic [NDW-1:0] out_node;
    logic [1:0]     out_stat;

    // ram controls
    logic           nb_we, nb_re;
    logic [AW-1:0]  nb_waddr, nb_raddr;
    logic [NDW-1:0] nb_wdata, nb_rdata;
    logic           dg_we, dg_re;
    logic [NW-1:0]  dg_waddr, dg_raddr;
    logic [DCW-1:0] dg_wdata, dg_rdata, deg_val;
    logic           st_we, st_re;
    logic [NW-1:0]  st_waddr, st_raddr;
    logic [SW-1:0]  st_wdata, st_rdata;
    logic           q_we, q_re;
    logic [NW-1:0]  q_waddr, q_raddr;
    logic [NDW-1:0] q_wdata, q_rdata;

    logic [NDW-1:0] in_a, in_b;
    logic [1:0]     in_cmd;
    logic [DCW:0]   k_idx;

    function automatic logic node_ok(input logic [NDW-1:0] n);
        return (n != '0) && ({1'b0, n} <= (NDW+1)'(MAX_NODES));
    endfunction

    function automatic logic [NW-1:0] nidx(input logic [NDW-1:0] n);
        logic [NDW-1:0] m;
        m = n - NDW'(1);
        return m[NW-1:0];
    endfunction

    function automatic logic [AW-1:0] naddr(input logic [NDW-1:0] n,
                                            input logic [DCW-1:0] i);
        logic [DIW-1:0] ii;
        ii = DIW'(i);
        return AW'(nidx(n)) * AW'(MAX_DEGREE) + AW'(ii);
    endfunction

    assign in_a   = s_tdata[5:0];
    assign in_b   = s_tdata[11:6];
    assign in_cmd = s_tuser;

    assign s_tready = (r_state == gdw_pkg::S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {r_ostat, r_onode};
    assign m_tlast  = r_olast;
    assign out_free = !r_ovalid || m_tready;
    assign deg_val  = r_rd_vld ? dg_rdata : '0;

    gdw_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES * MAX_DEGREE)) u_nb_ram (
        .i_clk(i_clk), .i_we(nb_we), .i_waddr(nb_waddr), .i_wdata(nb_wdata),
        .i_re(nb_re), .i_raddr(nb_raddr), .o_rdata(nb_rdata)
    );
    gdw_ram #(.WIDTH(DCW), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk(i_clk), .i_we(dg_we), .i_waddr(dg_waddr), .i_wdata(dg_wdata),
        .i_re(dg_re), .i_raddr(dg_raddr), .o_rdata(dg_rdata)
    );
    gdw_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack_ram (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );
    gdw_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gdw_pkg::S_IDLE;
            r_visited  <= '0;
            r_deg_vld  <= '0;
            r_pend_vld <= 1'b0;
            r_ovalid   <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_visited  <= n_visited;
            r_pend_vld <= n_pend_vld;
            if (dg_we) begin
                r_deg_vld[dg_waddr] <= 1'b1;
            end
            if (dg_re) begin
                r_rd_vld <= r_deg_vld[dg_raddr];
            end
            if (out_push) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_here   <= n_here;
        r_pend   <= n_pend;
        r_dega   <= n_dega;
        r_degb   <= n_degb;
        r_j      <= n_j;
        r_sp     <= n_sp;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_status <= n_status;
        if (out_push) begin
            r_onode <= out_node;
            r_ostat <= out_stat;
            r_olast <= out_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_here     = r_here;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_dega     = r_dega;
        n_degb     = r_degb;
        n_j        = r_j;
        n_sp       = r_sp;
        n_head     = r_head;
        n_tail     = r_tail;
        n_visited  = r_visited;
        n_status   = r_status;
        out_push   = 1'b0;
        out_node   = r_pend;
        out_stat   = gdw_pkg::ST_VISIT;
        out_last   = 1'b0;
        nb_we = 1'b0; nb_waddr = '0; nb_wdata = '0;
        nb_re = 1'b0; nb_raddr = '0;
        dg_we = 1'b0; dg_waddr = '0; dg_wdata = '0;
        dg_re = 1'b0; dg_raddr = '0;
        st_we = 1'b0; st_waddr = r_sp; st_wdata = {r_j, r_here};
        st_re = 1'b0; st_raddr = r_sp - NW'(1);
        q_we  = 1'b0; q_waddr = r_tail[NW-1:0]; q_wdata = '0;
        q_re  = 1'b0; q_raddr = r_head[NW-1:0];
        k_idx = ({1'b0, r_a} == {1'b0, r_b}) ? {1'b0, r_dega} + (DCW+1)'(1)
                                             : {1'b0, r_degb};

        case (r_state)
            gdw_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_a = in_a;
                    n_b = in_b;
                    case (in_cmd)
                        gdw_pkg::CMD_ADD: begin
                            if (node_ok(in_a) && node_ok(in_b)) begin
                                dg_re    = 1'b1;
                                dg_raddr = nidx(in_a);
                                n_state  = gdw_pkg::S_E_DEGA;
                            end else begin
                                n_status = gdw_pkg::ST_FULL;
                                n_state  = gdw_pkg::S_E_EMIT;
                            end
                        end
                        gdw_pkg::CMD_DFS, gdw_pkg::CMD_BFS: begin
                            if (node_ok(in_a)) begin
                                n_visited = '0;
                                n_visited[nidx(in_a)] = 1'b1;
                                n_pend     = in_a;
                                n_pend_vld = (in_cmd == gdw_pkg::CMD_DFS);
                                n_here     = in_a;
                                n_j        = '0;
                                n_sp       = '0;
                                if (in_cmd == gdw_pkg::CMD_DFS) begin
                                    n_state = gdw_pkg::S_D_LOAD;
                                end else begin
                                    q_we    = 1'b1;
                                    q_waddr = '0;
                                    q_wdata = in_a;
                                    n_head  = '0;
                                    n_tail  = QW'(1);
                                    n_state = gdw_pkg::S_B_POP;
                                end
                            end
                        end
                        default: begin
                            n_state = gdw_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            gdw_pkg::S_E_DEGA: begin
                n_dega   = deg_val;
                dg_re    = 1'b1;
                dg_raddr = nidx(r_b);
                n_state  = gdw_pkg::S_E_DEGB;
            end
            gdw_pkg::S_E_DEGB: begin
                n_degb  = deg_val;
                n_j     = '0;
                n_state = gdw_pkg::S_E_SCAN;
            end
            gdw_pkg::S_E_SCAN: begin
                if (r_j < r_dega) begin
                    nb_re    = 1'b1;
                    nb_raddr = naddr(r_a, r_j);
                    n_state  = gdw_pkg::S_E_CMP;
                end else if (r_a == r_b) begin
                    if ({1'b0, r_dega} + (DCW+1)'(2) > (DCW+1)'(MAX_DEGREE)) begin
                        n_status = gdw_pkg::ST_FULL;
                        n_state  = gdw_pkg::S_E_EMIT;
                    end else begin
                        n_state = gdw_pkg::S_E_WRA;
                    end
                end else if (r_dega >= DCW'(MAX_DEGREE) || r_degb >= DCW'(MAX_DEGREE)) begin
                    n_status = gdw_pkg::ST_FULL;
                    n_state  = gdw_pkg::S_E_EMIT;
                end else begin
                    n_state = gdw_pkg::S_E_WRA;
                end
            end
            gdw_pkg::S_E_CMP: begin
                if (nb_rdata == r_b) begin
                    n_status = gdw_pkg::ST_DUP;
                    n_state  = gdw_pkg::S_E_EMIT;
                end else begin
                    n_j     = r_j + DCW'(1);
                    n_state = gdw_pkg::S_E_SCAN;
                end
            end
            gdw_pkg::S_E_WRA: begin
                nb_we    = 1'b1;
                nb_waddr = naddr(r_a, r_dega);
                nb_wdata = r_b;
                dg_we    = 1'b1;
                dg_waddr = nidx(r_a);
                dg_wdata = r_dega + DCW'(1);
                n_state  = gdw_pkg::S_E_WRB;
            end
            gdw_pkg::S_E_WRB: begin
                // self loop takes the slot after the first append
                nb_we    = 1'b1;
                nb_waddr = naddr(r_b, k_idx[DCW-1:0]);
                nb_wdata = r_a;
                dg_we    = 1'b1;
                dg_waddr = nidx(r_b);
                dg_wdata = k_idx[DCW-1:0] + DCW'(1);
                n_status = gdw_pkg::ST_ADDED;
                n_state  = gdw_pkg::S_E_EMIT;
            end
            gdw_pkg::S_E_EMIT: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_node = '0;
                    out_stat = r_status;
                    out_last = 1'b1;
                    n_state  = gdw_pkg::S_IDLE;
                end
            end
            gdw_pkg::S_D_LOAD: begin
                dg_re    = 1'b1;
                dg_raddr = nidx(r_here);
                n_state  = gdw_pkg::S_D_LOADW;
            end
            gdw_pkg::S_D_LOADW: begin
                n_dega  = deg_val;
                n_state = gdw_pkg::S_D_STEP;
            end
            gdw_pkg::S_D_STEP: begin
                if (r_j < r_dega) begin
                    nb_re    = 1'b1;
                    nb_raddr = naddr(r_here, r_j);
                    n_j      = r_j + DCW'(1);
                    n_state  = gdw_pkg::S_D_NEXT;
                end else if (r_sp == '0) begin
                    n_state = gdw_pkg::S_FIN;
                end else begin
                    st_re   = 1'b1;
                    n_sp    = r_sp - NW'(1);
                    n_state = gdw_pkg::S_D_POPW;
                end
            end
            gdw_pkg::S_D_NEXT: begin
                if (node_ok(nb_rdata) && !r_visited[nidx(nb_rdata)]
                        && ({1'b0, r_sp} + (NW+1)'(1) < (NW+1)'(MAX_NODES))) begin
                    if (out_free) begin
                        // previous visit is not the last one
                        out_push = 1'b1;
                        n_pend   = nb_rdata;
                        n_visited[nidx(nb_rdata)] = 1'b1;
                        st_we    = 1'b1;
                        n_sp     = r_sp + NW'(1);
                        n_here   = nb_rdata;
                        n_j      = '0;
                        n_state  = gdw_pkg::S_D_LOAD;
                    end
                end else begin
                    n_state = gdw_pkg::S_D_STEP;
                end
            end
            gdw_pkg::S_D_POPW: begin
                n_here  = st_rdata[NDW-1:0];
                n_j     = st_rdata[SW-1:NDW];
                n_state = gdw_pkg::S_D_LOAD;
            end
            gdw_pkg::S_B_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    n_head  = r_head + QW'(1);
                    n_state = gdw_pkg::S_B_POPW;
                end else begin
                    n_state = gdw_pkg::S_FIN;
                end
            end
            gdw_pkg::S_B_POPW: begin
                n_here  = q_rdata;
                n_state = gdw_pkg::S_B_EMIT;
            end
            gdw_pkg::S_B_EMIT: begin
                if (!r_pend_vld || out_free) begin
                    out_push   = r_pend_vld;
                    n_pend     = r_here;
                    n_pend_vld = 1'b1;
                    dg_re      = 1'b1;
                    dg_raddr   = nidx(r_here);
                    n_state    = gdw_pkg::S_B_DEGW;
                end
            end
            gdw_pkg::S_B_DEGW: begin
                n_dega  = deg_val;
                n_j     = '0;
                n_state = gdw_pkg::S_B_SCAN;
            end
            gdw_pkg::S_B_SCAN: begin
                if (r_j < r_dega) begin
                    nb_re    = 1'b1;
                    nb_raddr = naddr(r_here, r_j);
                    n_j      = r_j + DCW'(1);
                    n_state  = gdw_pkg::S_B_CHK;
                end else begin
                    n_state = gdw_pkg::S_B_POP;
                end
            end
            gdw_pkg::S_B_CHK: begin
                if (node_ok(nb_rdata) && !r_visited[nidx(nb_rdata)]
                        && (r_tail < QW'(MAX_NODES))) begin
                    n_visited[nidx(nb_rdata)] = 1'b1;
                    q_we    = 1'b1;
                    q_wdata = nb_rdata;
                    n_tail  = r_tail + QW'(1);
                end
                n_state = gdw_pkg::S_B_SCAN;
            end
            gdw_pkg::S_FIN: begin
                if (out_free) begin
                    out_push   = 1'b1;
                    out_last   = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = gdw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for graph_dfs_bfs_walker: directed table then random edge/walk traffic
// predicts adjacency lists, dfs and bfs visit order; depends on gdw_pkg and the walker rtl
module testbench;

    localparam int NODES   = 32;
    localparam int DEGREE  = 32;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]       node;
        gdw_pkg::t_status stat;
        logic             last;
    } t_visit;

    typedef struct {
        gdw_pkg::t_cmd    cmd;
        logic [5:0]       a;
        logic [5:0]       b;
        logic             chk;     // typed-in expectation present
        gdw_pkg::t_status stat;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    graph_dfs_bfs_walker u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor state
    logic [5:0] adj [NODES][DEGREE];
    int         deg [NODES];
    bit         seen [NODES];
    t_visit     visit_q [$];

    int  err_cnt;
    int  idle_cnt;
    bit  no_idle;
    bit  sending;
    t_row rows [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit node_valid(int n);
        return n >= 1 && n <= NODES;
    endfunction

    function automatic gdw_pkg::t_status link_nodes(int a, int b);
        if (!node_valid(a) || !node_valid(b)) return gdw_pkg::ST_FULL;
        for (int i = 0; i < deg[a-1]; i++)
            if (adj[a-1][i] == b) return gdw_pkg::ST_DUP;
        if (a == b) begin
            if (deg[a-1] + 2 > DEGREE) return gdw_pkg::ST_FULL;
        end else if (deg[a-1] >= DEGREE || deg[b-1] >= DEGREE) begin
            return gdw_pkg::ST_FULL;
        end
        adj[a-1][deg[a-1]] = 6'(b); deg[a-1]++;
        adj[b-1][deg[b-1]] = 6'(a); deg[b-1]++;
        return gdw_pkg::ST_ADDED;
    endfunction

    // side-effect-free lookup of what an edge command would return
    function automatic gdw_pkg::t_status link_nodes_peek(int a, int b);
        if (!node_valid(a) || !node_valid(b)) return gdw_pkg::ST_FULL;
        for (int i = 0; i < deg[a-1]; i++)
            if (adj[a-1][i] == b) return gdw_pkg::ST_DUP;
        if (a == b)
            return (deg[a-1] + 2 > DEGREE) ? gdw_pkg::ST_FULL : gdw_pkg::ST_ADDED;
        return (deg[a-1] >= DEGREE || deg[b-1] >= DEGREE) ? gdw_pkg::ST_FULL
                                                           : gdw_pkg::ST_ADDED;
    endfunction

    // appends the expected visit sequence for one command
    task automatic predict_walk(gdw_pkg::t_cmd cmd, int a, int b);
        int stk_n [NODES];
        int stk_i [NODES];
        int fifo [NODES];
        int sp, hd, tl, here, nxt, n0;
        t_visit v;
        n0 = visit_q.size();
        if (cmd == gdw_pkg::CMD_ADD) begin
            v.node = '0; v.stat = link_nodes(a, b); v.last = 1'b1;
            visit_q = {visit_q, v};
            return;
        end
        if (cmd == gdw_pkg::CMD_NOP || !node_valid(a)) return;
        foreach (seen[i]) seen[i] = 0;
        v.stat = gdw_pkg::ST_VISIT; v.last = 1'b0;
        if (cmd == gdw_pkg::CMD_DFS) begin
            seen[a-1] = 1; v.node = 6'(a); visit_q = {visit_q, v};
            stk_n[0] = a; stk_i[0] = 0; sp = 1;
            while (sp > 0) begin
                here = stk_n[sp-1];
                if (stk_i[sp-1] < deg[here-1]) begin
                    nxt = adj[here-1][stk_i[sp-1]];
                    stk_i[sp-1]++;
                    if (node_valid(nxt) && !seen[nxt-1] && sp < NODES) begin
                        seen[nxt-1] = 1; v.node = 6'(nxt); visit_q = {visit_q, v};
                        stk_n[sp] = nxt; stk_i[sp] = 0; sp++;
                    end
                end else sp--;
            end
        end else begin
            hd = 0; tl = 0; seen[a-1] = 1; fifo[tl++] = a;
            while (hd < tl) begin
                here = fifo[hd++];
                v.node = 6'(here); visit_q = {visit_q, v};
                for (int j = 0; j < deg[here-1]; j++) begin
                    nxt = adj[here-1][j];
                    if (node_valid(nxt) && !seen[nxt-1] && tl < NODES) begin
                        seen[nxt-1] = 1; fifo[tl++] = nxt;
                    end
                end
            end
        end
        if (visit_q.size() > n0) visit_q[$].last = 1'b1;
    endtask

    // output side: random stall bursts, compare at the rising edge
    initial begin
        int burst;
        m_tready = 1'b0;
        err_cnt = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (burst) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_visit got, exp_v;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.node = m_tdata[5:0];
            got.stat = gdw_pkg::t_status'(m_tdata[7:6]);
            got.last = m_tlast;
            if (visit_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected transaction node=%0d stat=%0d last=%0d",
                             got.node, got.stat, got.last);
            end else begin
                exp_v = visit_q.pop_front();
                if (got != exp_v) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp node=%0d stat=%0d last=%0d, got %0d %0d %0d",
                                 exp_v.node, exp_v.stat, exp_v.last,
                                 got.node, got.stat, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else if (sending || visit_q.size() != 0) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WD_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // valid stays high into the next transaction unless an idle burst follows
    task automatic send_cmd(gdw_pkg::t_cmd cmd, logic [5:0] a, logic [5:0] b);
        s_tdata  <= {4'd0, b, a};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        predict_walk(cmd, a, b);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    function automatic t_row mk(gdw_pkg::t_cmd c, int a, int b, bit chk = 0,
                                gdw_pkg::t_status s = gdw_pkg::ST_ADDED);
        t_row r;
        r.cmd = c; r.a = 6'(a); r.b = 6'(b); r.chk = chk; r.stat = s;
        return r;
    endfunction

    initial begin
        int wait_cyc, nodes, r, a, b;
        gdw_pkg::t_cmd c;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        no_idle  = 0;
        sending  = 1;
        idle_cnt = 0;
        foreach (deg[i]) deg[i] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: typed-in status for edge rows that are obvious
        rows = {rows, mk(gdw_pkg::CMD_DFS, 1, 0)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 1, 2, 1, gdw_pkg::ST_ADDED)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 1, 2, 1, gdw_pkg::ST_DUP)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 2, 1, 1, gdw_pkg::ST_DUP)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 0, 2, 1, gdw_pkg::ST_FULL)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 3, 33, 1, gdw_pkg::ST_FULL)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 63, 63, 1, gdw_pkg::ST_FULL)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 32, 32, 1, gdw_pkg::ST_ADDED)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 32, 1)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 2, 5)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 1, 7)};
        rows = {rows, mk(gdw_pkg::CMD_DFS, 1, 0)};
        rows = {rows, mk(gdw_pkg::CMD_BFS, 1, 63)};
        rows = {rows, mk(gdw_pkg::CMD_DFS, 0, 0)};
        rows = {rows, mk(gdw_pkg::CMD_BFS, 33, 0)};
        rows = {rows, mk(gdw_pkg::CMD_NOP, 1, 2)};
        rows = {rows, mk(gdw_pkg::CMD_DFS, 9, 0)};
        rows = {rows, mk(gdw_pkg::CMD_BFS, 32, 0)};
        // fill node 3 to one free entry so a self loop runs out of room
        for (int k = 4; k <= 32; k++) rows = {rows, mk(gdw_pkg::CMD_ADD, 3, k)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 3, 1)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 3, 2)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 3, 3, 1, gdw_pkg::ST_FULL)};
        rows = {rows, mk(gdw_pkg::CMD_ADD, 3, 32, 1, gdw_pkg::ST_DUP)};
        rows = {rows, mk(gdw_pkg::CMD_DFS, 3, 0)};
        rows = {rows, mk(gdw_pkg::CMD_BFS, 3, 0)};

        foreach (rows[i]) begin
            if (rows[i].chk && rows[i].cmd == gdw_pkg::CMD_ADD
                    && !(rows[i].stat == gdw_pkg::ST_ADDED
                    && node_valid(rows[i].a) && node_valid(rows[i].b) && deg[rows[i].a-1] >=
                    DEGREE)) begin
                // predictor must agree with the typed-in code before it is queued
                if (link_nodes_peek(rows[i].a, rows[i].b) != rows[i].stat) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("table row %0d: status %0d not predicted", i, rows[i].stat);
                end
            end
            send_cmd(rows[i].cmd, rows[i].a, rows[i].b);
        end

        // random part: mostly edges mixed with walks, among 8 nodes and then all 32
        for (int n = 0; n < 170; n++) begin
            if (n > 150) no_idle = 1;
            nodes = (n < 85) ? 8 : 32;
            r = $urandom_range(0, 99);
            a = $urandom_range(1, nodes);
            b = $urandom_range(1, nodes);
            if (r < 55)      c = gdw_pkg::CMD_ADD;
            else if (r < 75) c = gdw_pkg::CMD_DFS;
            else if (r < 95) c = gdw_pkg::CMD_BFS;
            else begin
                c = gdw_pkg::t_cmd'($urandom_range(0, 3));
                a = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
            end
            send_cmd(c, 6'(a), 6'(b));
        end
        s_tvalid <= 1'b0;

        sending = 0;
        wait_cyc = 0;
        while (visit_q.size() != 0 && wait_cyc < 200000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && visit_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/gdw_pkg.sv
sv/gdw_ram.sv
sv/graph_dfs_bfs_walker.sv
tb/testbench.sv
